// File: hw/rtl/mbfpc_pkg.sv
// ----------------------------------------------------------------------------
// Burst-fire power controller package
// Shared types and constants for the mains burst-fire power controller.
// ----------------------------------------------------------------------------
package mbfpc_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_CROSS = 2'd1,
    OP_SET   = 2'd2
  } op_e;

  typedef logic signed [8:0] acc_t;
  typedef logic [6:0]        pct_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] tick_now;
    logic [2:0]  channel;
    logic [7:0]  percentage;
  } item_t;

  typedef struct packed {
    logic        power_present;
    logic [15:0] crossings_last_window;
    logic [7:0]  drive_bits;
    logic        drive_updated;
    logic        channel_rejected;
  } result_t;

  localparam logic [31:0] WindowTicksReset = 32'd1000;
  localparam logic [15:0] MainsCountLow    = 16'd95;
  localparam logic [15:0] MainsCountHigh   = 16'd105;
  localparam logic [15:0] CountFull        = 16'hFFFF;
  localparam acc_t        FireThreshold    = 9'sd50;
  localparam acc_t        FireStep         = 9'sd100;
  localparam acc_t        AccMin           = -9'sd50;
  localparam acc_t        AccMax           = 9'sd49;
  localparam logic [7:0]  PercentMax       = 8'd100;

endpackage

// File: hw/rtl/mains_burst_fire_power_controller_top.sv
// ----------------------------------------------------------------------------
// Mains burst-fire power controller
// Counts mains zero crossings, checks the count once per tick window and
// drives heater channels by burst-fire error accumulation.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                          Direction
//  input     in_valid_i / in_ready_o, op_i .. percentage_i    into block
//  result    out_valid_o / out_ready_i, status fields         out of block
//  config    cfg_valid_i / cfg_ready_o, window ticks          into block
//
// An accepted transaction is held in an input register and its result is
// written into the result register when that register is empty or being read,
// so one transaction per cycle is sustained while results are taken.
// All state but the configured window length is updated when a transaction
// moves from the input register into the result register. A stalled result
// register holds the input register, which in turn drops in_ready_o.
// Reset loads a window of 1000 ticks and clears all state but the input and result data registers.
// ----------------------------------------------------------------------------
module mains_burst_fire_power_controller_top #(
  parameter int unsigned CHANNELS = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] tick_now_i,
  input  logic [2:0]  channel_i,
  input  logic [7:0]  percentage_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        power_present_o,
  output logic [15:0] crossings_last_window_o,
  output logic [7:0]  drive_bits_o,
  output logic        drive_updated_o,
  output logic        channel_rejected_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_window_ticks_i
);
  import mbfpc_pkg::*;

  localparam logic [3:0] ChanLimit = 4'(CHANNELS);

  logic                  in_valid_q;
  item_t                 in_q;
  logic                  advance;
  logic                  out_valid_q;
  result_t               res_q, res_d;

  logic [31:0]           window_ticks_q;
  logic [31:0]           window_start_q, window_start_d;
  logic [15:0]           count_q, count_d;
  logic [15:0]           last_count_q, last_count_d;
  logic                  mains_ok_q, mains_ok_d;
  pct_t                  setting_q [CHANNELS];
  pct_t                  setting_d [CHANNELS];
  acc_t                  acc_q [CHANNELS];
  acc_t                  acc_d [CHANNELS];
  logic [CHANNELS-1:0]   drive_q, drive_d;

  logic [15:0]           count_inc;
  logic [31:0]           window_end;
  pct_t                  pct_sat;
  acc_t                  sum [CHANNELS];

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  assign count_inc  = (count_q != CountFull) ? count_q + 16'd1 : count_q;
  assign window_end = window_start_q + window_ticks_q;
  assign pct_sat    = (in_q.percentage > PercentMax) ? PercentMax[6:0] : in_q.percentage[6:0];

  always_comb begin
    window_start_d = window_start_q;
    count_d        = count_q;
    last_count_d   = last_count_q;
    mains_ok_d     = mains_ok_q;
    setting_d      = setting_q;
    acc_d          = acc_q;
    drive_d        = drive_q;
    res_d          = '0;

    for (int i = 0; i < CHANNELS; i++) begin
      sum[i] = acc_q[i] + acc_t'({2'b00, setting_q[i]});
    end

    unique case (op_e'(in_q.op))
      OP_TICK: begin
        if (window_end < in_q.tick_now) begin
          window_start_d = in_q.tick_now;
          last_count_d   = count_q;
          count_d        = '0;
          if (count_q > MainsCountLow && count_q < MainsCountHigh) begin
            mains_ok_d = 1'b1;
          end else begin
            mains_ok_d          = 1'b0;
            res_d.drive_updated = 1'b1;
            drive_d             = '0;
            for (int i = 0; i < CHANNELS; i++) begin
              setting_d[i] = '0;
              acc_d[i]     = '0;
            end
          end
        end
      end
      OP_CROSS: begin
        count_d = count_inc;
        if (count_inc[0]) begin
          res_d.drive_updated = 1'b1;
          for (int i = 0; i < CHANNELS; i++) begin
            if (sum[i] >= FireThreshold) begin
              drive_d[i] = 1'b1;
              acc_d[i]   = sum[i] - FireStep;
            end else begin
              drive_d[i] = 1'b0;
              acc_d[i]   = sum[i];
            end
          end
        end
      end
      OP_SET: begin
        if ({1'b0, in_q.channel} < ChanLimit) begin
          for (int i = 0; i < CHANNELS; i++) begin
            if (in_q.channel == 3'(i)) begin
              setting_d[i] = pct_sat;
            end
          end
        end else begin
          res_d.channel_rejected = 1'b1;
        end
      end
      default: begin
      end
    endcase

    res_d.power_present         = mains_ok_d;
    res_d.crossings_last_window = last_count_d;
    res_d.drive_bits            = 8'(drive_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      window_ticks_q <= WindowTicksReset;
      window_start_q <= '0;
      count_q        <= '0;
      last_count_q   <= '0;
      mains_ok_q     <= 1'b0;
      drive_q        <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        setting_q[i] <= '0;
        acc_q[i]     <= '0;
      end
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        window_ticks_q <= cfg_window_ticks_i;
      end
      if (advance) begin
        window_start_q <= window_start_d;
        count_q        <= count_d;
        last_count_q   <= last_count_d;
        mains_ok_q     <= mains_ok_d;
        drive_q        <= drive_d;
        setting_q      <= setting_d;
        acc_q          <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= '{op: op_i, tick_now: tick_now_i, channel: channel_i,
                percentage: percentage_i};
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign power_present_o         = res_q.power_present;
  assign crossings_last_window_o = res_q.crossings_last_window;
  assign drive_bits_o            = res_q.drive_bits;
  assign drive_updated_o         = res_q.drive_updated;
  assign channel_rejected_o      = res_q.channel_rejected;

  // A rejected channel write never touches the drives.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && channel_rejected_o |-> !drive_updated_o)
    else $error("rejected channel write also updated the drives");

  // Drive bits for channels that do not exist stay low.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (drive_bits_o >> CHANNELS) == 8'd0)
    else $error("drive bit set for a channel that does not exist");

  // A window judged bad leaves every drive off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && drive_updated_o && !power_present_o && $past(advance)
      && $past(in_q.op) == OP_TICK |-> drive_bits_o == 8'd0)
    else $error("safe state left a heater driven");

  for (genvar g = 0; g < CHANNELS; g++) begin : g_acc_chk
    // Error accumulators stay within one firing step around zero.
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      acc_q[g] >= AccMin && acc_q[g] <= AccMax)
      else $error("error accumulator out of range");
  end

endmodule

// File: sim/mains_burst_fire_power_controller_top_test.sv
// ----------------------------------------------------------------------------
// Burst-fire power controller testbench
// Drives tick, crossing and power-setting transactions into the controller
// and checks every status result against a cycle-free model of the counter,
// the window check and the per-channel error accumulators kept here.
// ----------------------------------------------------------------------------
module mains_burst_fire_power_controller_top_test;
  import mbfpc_pkg::*;

  localparam int          Channels = 2;
  localparam int          ChanW    = (Channels > 1) ? $clog2(Channels) : 1;
  localparam logic [1:0]  OpUnused = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  op_i;
  logic [31:0] tick_now_i;
  logic [2:0]  channel_i;
  logic [7:0]  percentage_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        power_present_o;
  logic [15:0] crossings_last_window_o;
  logic [7:0]  drive_bits_o;
  logic        drive_updated_o;
  logic        channel_rejected_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [31:0] cfg_window_ticks_i;

  mains_burst_fire_power_controller_top #(
    .CHANNELS(Channels)
  ) u_top (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_ready_o             (in_ready_o),
    .op_i                   (op_i),
    .tick_now_i             (tick_now_i),
    .channel_i              (channel_i),
    .percentage_i           (percentage_i),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .power_present_o        (power_present_o),
    .crossings_last_window_o(crossings_last_window_o),
    .drive_bits_o           (drive_bits_o),
    .drive_updated_o        (drive_updated_o),
    .channel_rejected_o     (channel_rejected_o),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_window_ticks_i     (cfg_window_ticks_i)
  );

  // Controller state as the status results should reflect it.
  logic [31:0] window_len;
  logic [31:0] window_begin;
  logic [15:0] zc_count;
  logic [15:0] zc_last;
  logic        mains_good;
  pct_t        heat_pct [Channels];
  acc_t        heat_err [Channels];
  logic        heat_on  [Channels];

  result_t status_due [$];
  int      fail_count;
  int      items_sent;
  int      send_idle_pct;
  int      recv_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("mains_burst_fire_power_controller_top_test failed");
    $finish;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void clear_heaters();
    for (int i = 0; i < Channels; i++) begin
      heat_pct[i] = '0;
      heat_err[i] = '0;
      heat_on[i]  = 1'b0;
    end
  endfunction

  function automatic result_t step_controller(item_t it);
    result_t     r;
    logic [31:0] win_end;
    int          s;
    r = '0;
    case (it.op)
      OP_TICK: begin
        win_end = window_begin + window_len;
        if (win_end < it.tick_now) begin
          window_begin = it.tick_now;
          mains_good = (zc_count > MainsCountLow) && (zc_count < MainsCountHigh);
          if (!mains_good) begin
            clear_heaters();
            r.drive_updated = 1'b1;
          end
          zc_last  = zc_count;
          zc_count = '0;
        end
      end
      OP_CROSS: begin
        if (zc_count != CountFull) begin
          zc_count++;
        end
        if (zc_count[0]) begin
          for (int i = 0; i < Channels; i++) begin
            s = int'(heat_err[i]) + int'(heat_pct[i]);
            heat_on[i] = (s >= int'(FireThreshold));
            if (heat_on[i]) begin
              s -= int'(FireStep);
            end
            heat_err[i] = acc_t'(s);
          end
          r.drive_updated = 1'b1;
        end
      end
      OP_SET: begin
        if (it.channel < Channels) begin
          heat_pct[ChanW'(it.channel)] = (it.percentage > PercentMax) ? pct_t'(PercentMax)
                                                                      : it.percentage[6:0];
        end else begin
          r.channel_rejected = 1'b1;
        end
      end
      default: ;
    endcase
    r.power_present         = mains_good;
    r.crossings_last_window = zc_last;
    for (int i = 0; i < Channels; i++) begin
      r.drive_bits[i] = heat_on[i];
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{power_present_o, crossings_last_window_o, drive_bits_o,
              drive_updated_o, channel_rejected_o};
      if (status_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        fail_count++;
      end else begin
        want = status_due.pop_front();
        check_field("power_present", 32'(want.power_present), 32'(got.power_present));
        check_field("crossings_last_window", 32'(want.crossings_last_window),
                    32'(got.crossings_last_window));
        check_field("drive_bits", 32'(want.drive_bits), 32'(got.drive_bits));
        check_field("drive_updated", 32'(want.drive_updated), 32'(got.drive_updated));
        check_field("channel_rejected", 32'(want.channel_rejected),
                    32'(got.channel_rejected));
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [31:0] now,
                           input logic [2:0] ch, input logic [7:0] pct);
    item_t it;
    it = '{op, now, ch, pct};
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    tick_now_i   <= now;
    channel_i    <= ch;
    percentage_i <= pct;
    do @(posedge clk_i); while (!in_ready_o);
    status_due.push_back(step_controller(it));
    items_sent++;
  endtask

  task automatic send_tick(input logic [31:0] now);
    send_item(OP_TICK, now, 3'($urandom_range(7)), 8'($urandom_range(255)));
  endtask

  task automatic send_cross();
    send_item(OP_CROSS, $urandom, 3'($urandom_range(7)), 8'($urandom_range(255)));
  endtask

  task automatic send_set(input logic [2:0] ch, input logic [7:0] pct);
    send_item(OP_SET, $urandom, ch, pct);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [31:0] ticks);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i        <= 1'b1;
    cfg_window_ticks_i <= ticks;
    do @(posedge clk_i); while (!cfg_ready_o);
    window_len = ticks;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_opcodes();
    send_set(3'd0, 8'hFF);
    send_set(3'd1, 8'd50);
    send_set(3'd7, 8'd0);
    send_set(3'd2, 8'd101);
    send_item(OpUnused, 32'hFFFF_FFFF, 3'd7, 8'hFF);
    repeat (4) send_cross();
    send_set(3'd1, 8'd100);
    send_cross();
    send_cross();
    send_tick(32'd0);
    send_tick(32'hFFFF_FFFF);
    // The window end now wraps past zero.
    send_tick(32'd500);
    send_tick(32'd1000);
  endtask

  task automatic test_window_edges();
    write_window(32'd0);
    send_tick(window_begin);
    send_tick(window_begin + 32'd1);
    write_window(32'hFFFF_FFFF);
    send_tick(window_begin - 32'd2);
    send_tick(window_begin);
    write_window(32'd1);
    send_tick(window_begin + 32'd1);
    send_tick(window_begin + 32'd2);
  endtask

  task automatic test_mains_limits();
    int counts [5] = '{95, 96, 104, 105, 100};
    write_window(32'd5000);
    foreach (counts[k]) begin
      send_set(3'd0, 8'd30 + 8'(k * 17));
      send_set(3'd1, 8'd75);
      repeat (counts[k]) send_cross();
      send_tick(window_begin + window_len + 32'd1);
    end
  endtask

  task automatic test_random_traffic(input int n_items, input int s_idle, input int r_idle);
    int target;
    int count;
    int pick;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    write_window($urandom_range(3000, 20));
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(99) < 80) begin
        pick = $urandom_range(99);
        count = (pick < 85) ? $urandom_range(107, 93) : $urandom_range(200);
        repeat (count) begin
          send_cross();
          if ($urandom_range(99) < 15) begin
            send_set(($urandom_range(99) < 85) ? 3'($urandom_range(Channels - 1))
                                               : 3'($urandom_range(7)),
                     ($urandom_range(99) < 85) ? 8'($urandom_range(100))
                                               : 8'($urandom_range(255)));
          end
          if ($urandom_range(99) < 10) begin
            send_tick(window_begin + $urandom_range(window_len));
          end
        end
        if ($urandom_range(99) < 90) begin
          send_tick(window_begin + window_len + $urandom_range(64, 1));
        end
      end else begin
        repeat ($urandom_range(10, 1)) begin
          send_item(2'($urandom_range(3)), $urandom, 3'($urandom_range(7)),
                    8'($urandom_range(255)));
        end
      end
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    op_i               = '0;
    tick_now_i         = '0;
    channel_i          = '0;
    percentage_i       = '0;
    out_ready_i        = 1'b0;
    cfg_valid_i        = 1'b0;
    cfg_window_ticks_i = '0;
    fail_count         = 0;
    items_sent         = 0;
    send_idle_pct      = 28;
    recv_idle_pct      = 54;
    window_len         = WindowTicksReset;
    window_begin       = '0;
    zc_count           = '0;
    zc_last            = '0;
    mains_good         = 1'b0;
    clear_heaters();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_opcodes();
    test_window_edges();
    test_mains_limits();
    test_random_traffic(300, 28, 54);
    test_random_traffic(300, 54, 28);
    test_random_traffic(300, 0, 0);
    wait_drained();

    if (fail_count == 0) begin
      $display("mains_burst_fire_power_controller_top_test passed");
    end else begin
      $display("mains_burst_fire_power_controller_top_test failed");
    end
    $finish;
  end

endmodule
